@@ hw/rtl/qma_pkg.sv @@
`default_nettype none

package qma_pkg;

	localparam int unsigned VAL_W     = 16;
	localparam int unsigned LEVEL_W   = 15;
	localparam int unsigned BITS_W    = 12;
	localparam int unsigned LANES     = 4;
	localparam int unsigned IDX_W     = 3;
	localparam int unsigned PROD_W    = 34;
	localparam int unsigned ACC_W     = 18;
	localparam int unsigned SHIFT_Q15 = 15;

	localparam logic [LEVEL_W-1:0] QPSK_SCALE_Q15 = 15'd23170;

	localparam logic [1:0] MOD_QPSK  = 2'd0;
	localparam logic [1:0] MOD_QAM16 = 2'd1;
	localparam logic [1:0] MOD_QAM64 = 2'd2;

	localparam logic [1:0] ANT_SINGLE   = 2'd0;
	localparam logic [1:0] ANT_ALAMOUTI = 2'd1;
	localparam logic [1:0] ANT_CYCLE    = 2'd2;

	localparam logic [IDX_W-1:0] REG_MODULATION = 3'd0;
	localparam logic [IDX_W-1:0] REG_ANT_MODE   = 3'd1;
	localparam logic [IDX_W-1:0] REG_AMPLITUDE  = 3'd2;
	localparam logic [IDX_W-1:0] REG_Q16_A      = 3'd3;
	localparam logic [IDX_W-1:0] REG_Q16_B      = 3'd4;
	localparam logic [IDX_W-1:0] REG_Q64_A      = 3'd5;
	localparam logic [IDX_W-1:0] REG_Q64_B      = 3'd6;
	localparam logic [IDX_W-1:0] REG_Q64_C      = 3'd7;

	typedef struct packed {
		logic [1:0] mode;
		logic       odd;
		logic       mod_ok;
	} ctl_t;

	typedef struct packed {
		logic [VAL_W-1:0] r0;
		logic [VAL_W-1:0] i0;
		logic [VAL_W-1:0] r1;
		logic [VAL_W-1:0] i1;
		logic             w0;
		logic             w1;
		logic             step;
		logic             last;
	} res_t;

	function automatic logic [VAL_W-1:0] neg16(input logic [VAL_W-1:0] x);
		return VAL_W'(~x + 1'b1);
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/qma_lane.sv @@
`default_nettype none

module qma_lane import qma_pkg::*; #(
	parameter logic [LEVEL_W-1:0] QPSK_SCALE = QPSK_SCALE_Q15
) (
	input  wire                 clk,
	input  wire                 en,
	input  wire [2:0]           bits,
	input  wire [1:0]           modulation,
	input  wire [LEVEL_W-1:0]   amplitude,
	input  wire [LEVEL_W-1:0]   q16_a,
	input  wire [LEVEL_W-1:0]   q16_b,
	input  wire [LEVEL_W-1:0]   q64_a,
	input  wire [LEVEL_W-1:0]   q64_b,
	input  wire [LEVEL_W-1:0]   q64_c,
	output logic [VAL_W-1:0]    value
);

	logic signed [ACC_W-1:0]  level;
	logic signed [ACC_W-1:0]  t_inner;
	logic signed [ACC_W-1:0]  t_mid;
	logic signed [ACC_W-1:0]  t_top;
	logic                     neg;
	logic                     zero;
	logic signed [ACC_W-1:0]  level_s1;
	logic                     neg_s1;
	logic                     zero_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     neg_s2;
	logic                     zero_s2;
	logic [VAL_W-1:0]         mag;

	always_comb begin
		level   = '0;
		neg     = 1'b0;
		zero    = 1'b0;
		t_inner = '0;
		t_mid   = '0;
		t_top   = '0;
		case (modulation)
			MOD_QPSK: begin
				level = signed'(ACC_W'(QPSK_SCALE));
				neg   = ~bits[0];
			end
			MOD_QAM16: begin
				t_mid = signed'(ACC_W'(q16_b));
				t_mid = bits[1] ? t_mid : -t_mid;
				t_top = signed'(ACC_W'(q16_a)) + t_mid;
				level = bits[0] ? t_top : -t_top;
			end
			MOD_QAM64: begin
				t_inner = signed'(ACC_W'(q64_c));
				t_inner = bits[2] ? t_inner : -t_inner;
				t_mid   = signed'(ACC_W'(q64_b)) + t_inner;
				t_mid   = bits[1] ? t_mid : -t_mid;
				t_top   = signed'(ACC_W'(q64_a)) + t_mid;
				level   = bits[0] ? t_top : -t_top;
			end
			default: begin
				zero = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			level_s1 <= level;
			neg_s1   <= neg;
			zero_s1  <= zero;
			prod_s2  <= PROD_W'(signed'({1'b0, amplitude}) * level_s1);
			neg_s2   <= neg_s1;
			zero_s2  <= zero_s1;
		end
	end

	// Floor shift by 15 and wrap to 16 bits is a plain bit select.
	assign mag = prod_s2[SHIFT_Q15 +: VAL_W];

	always_comb begin
		if (zero_s2) begin
			value = '0;
		end else if (neg_s2) begin
			value = neg16(mag);
		end else begin
			value = mag;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/qma_merge.sv @@
`default_nettype none

module qma_merge import qma_pkg::*; (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               load,
	input  wire ctl_t         ctl,
	input  wire [VAL_W-1:0]   x0r,
	input  wire [VAL_W-1:0]   x0i,
	input  wire [VAL_W-1:0]   x1r,
	input  wire [VAL_W-1:0]   x1i,
	output logic              free,
	output logic              m_tvalid,
	input  wire               m_tready,
	output logic [63:0]       m_tdata,
	output logic [2:0]        m_tuser,
	output logic              m_tlast
);

	logic valid_q;
	logic phase_q;
	logic two_q;
	res_t res0_q;
	res_t res1_q;
	res_t res0;
	res_t res1;
	res_t cur;

	assign free = ~valid_q | (m_tready & (~two_q | phase_q));

	always_comb begin
		res0 = '0;
		res1 = '0;
		if (ctl.mode == ANT_ALAMOUTI) begin
			res0 = '{r0: x0r, i0: x0i, r1: neg16(x1r), i1: x1i,
				w0: ctl.mod_ok, w1: ctl.mod_ok, step: 1'b0, last: 1'b0};
			res1 = '{r0: x1r, i0: x1i, r1: x0r, i1: neg16(x0i),
				w0: ctl.mod_ok, w1: ctl.mod_ok, step: 1'b1, last: 1'b1};
		end else if (ctl.mode == ANT_CYCLE && ctl.odd) begin
			res0.r1   = x0r;
			res0.i1   = x0i;
			res0.w1   = ctl.mod_ok;
			res0.last = 1'b1;
		end else begin
			res0.r0   = x0r;
			res0.i0   = x0i;
			res0.w0   = ctl.mod_ok;
			res0.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
			two_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				phase_q <= 1'b0;
				two_q   <= (ctl.mode == ANT_ALAMOUTI);
			end else if (valid_q && m_tready) begin
				if (two_q && !phase_q) begin
					phase_q <= 1'b1;
				end else begin
					valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res0_q <= res0;
			res1_q <= res1;
		end
	end

	assign cur      = phase_q ? res1_q : res0_q;
	assign m_tvalid = valid_q;
	assign m_tdata  = {cur.i1, cur.r1, cur.i0, cur.r0};
	assign m_tuser  = {cur.step, cur.w1, cur.w0};
	assign m_tlast  = cur.last;

endmodule

`default_nettype wire

@@ hw/rtl/qam_mapper_alamouti_core.sv @@
// QAM mapper with Alamouti precoding.
// Input stream: s_tdata[11:0] carries the coded bits (bit 0 first in the stream),
// and s_tuser carries the subcarrier parity. A transfer on the input is one subcarrier,
// or one subcarrier pair in Alamouti mode.
// Output stream: m_tdata carries the four antenna values, m_tuser the two write flags
// and the subcarrier step, and m_tlast marks the final result of an input transfer.
// Single-antenna and cycling modes give one result per input; Alamouti gives two.
// Four axis lanes map and scale in parallel; each lane has a level stage and a
// multiply stage, and a merge stage builds the results into an output register.
// The block takes one input per cycle while the receiver is ready; in Alamouti mode
// it holds the next input while the output register emits the first of its two results,
// and the output register emits one result per cycle while the receiver is ready.
// When the receiver stalls, the whole pipeline holds and s_tready drops.
// Reset clears the pipeline and sets the registers to QPSK, single antenna and full
// amplitude. Registers are written on the cfg channel, which is always ready; the user must
// write them only while the block is idle, which the block itself does not enforce.
`default_nettype none

module qam_mapper_alamouti_core import qma_pkg::*; #(
	parameter logic [LEVEL_W-1:0] QPSK_SCALE = QPSK_SCALE_Q15
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire [IDX_W-1:0]   cfg_index,
	input  wire [14:0]        cfg_data,
	input  wire               s_tvalid,
	output logic              s_tready,
	input  wire [15:0]        s_tdata,  // [11:0] coded_bits, rest zero
	input  wire               s_tuser,  // [0] re_odd
	output logic              m_tvalid,
	input  wire               m_tready,
	output logic [63:0]       m_tdata,  // ant0_real, ant0_imag, ant1_real, ant1_imag
	output logic [2:0]        m_tuser,  // [0] ant0_write, [1] ant1_write, [2] carrier_step
	output logic              m_tlast
);

	logic [1:0]         modulation_q;
	logic [1:0]         ant_mode_q;
	logic [LEVEL_W-1:0] amplitude_q;
	logic [LEVEL_W-1:0] q16_a_q;
	logic [LEVEL_W-1:0] q16_b_q;
	logic [LEVEL_W-1:0] q64_a_q;
	logic [LEVEL_W-1:0] q64_b_q;
	logic [LEVEL_W-1:0] q64_c_q;

	logic               adv;
	logic               valid_s1;
	logic               valid_s2;
	ctl_t               ctl_in;
	ctl_t               ctl_s1;
	ctl_t               ctl_s2;
	logic [BITS_W-1:0]  cb;
	logic [2:0]         lane_bits [LANES];
	logic [VAL_W-1:0]   lane_val  [LANES];
	logic               load;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulation_q <= MOD_QPSK;
			ant_mode_q   <= ANT_SINGLE;
			amplitude_q  <= 15'h7FFF;
			q16_a_q      <= '0;
			q16_b_q      <= '0;
			q64_a_q      <= '0;
			q64_b_q      <= '0;
			q64_c_q      <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODULATION: modulation_q <= cfg_data[1:0];
				REG_ANT_MODE:   ant_mode_q   <= cfg_data[1:0];
				REG_AMPLITUDE:  amplitude_q  <= cfg_data;
				REG_Q16_A:      q16_a_q      <= cfg_data;
				REG_Q16_B:      q16_b_q      <= cfg_data;
				REG_Q64_A:      q64_a_q      <= cfg_data;
				REG_Q64_B:      q64_b_q      <= cfg_data;
				REG_Q64_C:      q64_c_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cb       = s_tdata[BITS_W-1:0];
	assign s_tready = adv;

	// Axis order in the stream: x0 real, x0 imag, x1 real, x1 imag.
	always_comb begin
		case (modulation_q)
			MOD_QPSK: begin
				lane_bits[0] = 3'(cb);
				lane_bits[1] = 3'(cb >> 1);
				lane_bits[2] = 3'(cb >> 2);
				lane_bits[3] = 3'(cb >> 3);
			end
			MOD_QAM16: begin
				lane_bits[0] = 3'(cb);
				lane_bits[1] = 3'(cb >> 2);
				lane_bits[2] = 3'(cb >> 4);
				lane_bits[3] = 3'(cb >> 6);
			end
			MOD_QAM64: begin
				lane_bits[0] = 3'(cb);
				lane_bits[1] = 3'(cb >> 3);
				lane_bits[2] = 3'(cb >> 6);
				lane_bits[3] = 3'(cb >> 9);
			end
			default: begin
				lane_bits[0] = '0;
				lane_bits[1] = '0;
				lane_bits[2] = '0;
				lane_bits[3] = '0;
			end
		endcase
	end

	always_comb begin
		ctl_in.mode   = ant_mode_q;
		ctl_in.odd    = s_tuser;
		ctl_in.mod_ok = modulation_q inside {MOD_QPSK, MOD_QAM16, MOD_QAM64};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		qma_lane #(
			.QPSK_SCALE (QPSK_SCALE)
		) u_lane (
			.clk        (clk),
			.en         (adv),
			.bits       (lane_bits[g]),
			.modulation (modulation_q),
			.amplitude  (amplitude_q),
			.q16_a      (q16_a_q),
			.q16_b      (q16_b_q),
			.q64_a      (q64_a_q),
			.q64_b      (q64_b_q),
			.q64_c      (q64_c_q),
			.value      (lane_val[g])
		);
	end

	// Items in the unused antenna mode produce no result.
	assign load = adv & valid_s2 & (ctl_s2.mode inside {ANT_SINGLE, ANT_ALAMOUTI, ANT_CYCLE});

	qma_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.ctl      (ctl_s2),
		.x0r      (lane_val[0]),
		.x0i      (lane_val[1]),
		.x1r      (lane_val[2]),
		.x1i      (lane_val[3]),
		.free     (adv),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
	import qma_pkg::*;

	localparam logic [1:0] MOD_UNUSED = 2'd3;
	localparam logic [1:0] ANT_UNUSED = 2'd3;
	localparam int unsigned SETTINGS_PER_PHASE = 10;
	localparam int unsigned ITEMS_PER_SETTING = 50;

	typedef struct {
		logic             is_cfg;
		logic [IDX_W-1:0] idx;
		logic [14:0]      val;
		logic [11:0]      bits;
		logic             odd;
		logic             typed;
		res_t             want;
	} stim_row_t;

	typedef struct {
		logic [IDX_W-1:0] idx;
		logic [14:0]      val;
	} reg_wr_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [IDX_W-1:0]   cfg_index;
	logic [14:0]        cfg_data;
	logic               s_tvalid;
	logic               s_tready;
	logic [15:0]        s_tdata;
	logic               s_tuser;
	logic               m_tvalid;
	logic               m_tready;
	logic [63:0]        m_tdata;
	logic [2:0]         m_tuser;
	logic               m_tlast;

	logic [1:0]         mod_r;
	logic [1:0]         ant_r;
	logic [14:0]        amp_r;
	logic [14:0]        q16a_r;
	logic [14:0]        q16b_r;
	logic [14:0]        q64a_r;
	logic [14:0]        q64b_r;
	logic [14:0]        q64c_r;

	res_t               pending_carriers[$];
	reg_wr_t            reg_plan[$];
	stim_row_t          plan[$];
	res_t               want_c;
	int                 send_pct;
	int                 recv_pct;
	int                 mismatches;
	int                 items_sent;
	int                 results_checked;
	int                 settings_used;

	qam_mapper_alamouti_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always #10 clk = ~clk;

	function automatic logic [15:0] flip16(logic [15:0] x);
		return 16'h0 - x;
	endfunction

	function automatic res_t mk_res(logic [15:0] r0, logic [15:0] i0, logic [15:0] r1,
			logic [15:0] i1, logic w0, logic w1, logic step, logic last);
		res_t x;
		x.r0 = r0;
		x.i0 = i0;
		x.r1 = r1;
		x.i1 = i1;
		x.w0 = w0;
		x.w1 = w1;
		x.step = step;
		x.last = last;
		return x;
	endfunction

	// One axis: the first stream bit is the sign, later bits pick the inner levels.
	function automatic logic [15:0] axis_val(logic [2:0] b);
		longint sa;
		longint sb;
		longint sc;
		longint lvl;
		longint prod;
		logic [31:0] g;
		sa = b[0] ? 1 : -1;
		sb = b[1] ? 1 : -1;
		sc = b[2] ? 1 : -1;
		case (mod_r)
			MOD_QPSK: begin
				g = (32'(amp_r) * 32'(QPSK_SCALE_Q15)) >> 15;
				return b[0] ? g[15:0] : flip16(g[15:0]);
			end
			MOD_QAM16: lvl = sa * (longint'(q16a_r) + sb * longint'(q16b_r));
			MOD_QAM64: lvl = sa * (longint'(q64a_r) + sb * (longint'(q64b_r) +
					sc * longint'(q64c_r)));
			default: return 16'h0;
		endcase
		prod = longint'(amp_r) * lvl;
		prod = prod >>> 15;
		return prod[15:0];
	endfunction

	function automatic void map_item(logic [11:0] bits, logic odd);
		logic [15:0] r0;
		logic [15:0] i0;
		logic [15:0] r1;
		logic [15:0] i1;
		logic        ok;
		int          m;
		ok = (mod_r != MOD_UNUSED);
		m = int'(mod_r) + 1;
		r0 = axis_val(3'(bits));
		i0 = axis_val(3'(bits >> m));
		case (ant_r)
			ANT_SINGLE, ANT_CYCLE: begin
				if (ant_r == ANT_CYCLE && odd)
					pending_carriers.push_back(mk_res(16'h0, 16'h0, r0, i0, 1'b0, ok,
							1'b0, 1'b1));
				else
					pending_carriers.push_back(mk_res(r0, i0, 16'h0, 16'h0, ok, 1'b0,
							1'b0, 1'b1));
			end
			ANT_ALAMOUTI: begin
				r1 = flip16(axis_val(3'(bits >> (2 * m))));
				i1 = axis_val(3'(bits >> (3 * m)));
				pending_carriers.push_back(mk_res(r0, i0, r1, i1, ok, ok, 1'b0, 1'b0));
				pending_carriers.push_back(mk_res(flip16(r1), i1, r0, flip16(i0), ok, ok,
						1'b1, 1'b1));
			end
			default: ;
		endcase
	endfunction

	function automatic stim_row_t cfg_row(logic [IDX_W-1:0] idx, logic [14:0] val);
		stim_row_t r;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.val = val;
		r.bits = '0;
		r.odd = 1'b0;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic stim_row_t item_row(logic [11:0] bits, logic odd, logic typed,
			res_t want);
		stim_row_t r;
		r.is_cfg = 1'b0;
		r.idx = '0;
		r.val = '0;
		r.bits = bits;
		r.odd = odd;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	function automatic logic [14:0] pick_level();
		int sel;
		sel = $urandom_range(7);
		if (sel == 0)
			return 15'd0;
		if (sel == 1)
			return 15'd32767;
		return 15'($urandom_range(32767));
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		mismatches++;
		if (mismatches <= 30)
			$display("%0t ns: %s got %h, expected %h", $time, what, got, want);
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_pct);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_carriers.size() == 0) begin
				report_mismatch("result transfer with nothing pending", m_tdata[15:0], 16'h0);
			end else begin
				want_c = pending_carriers.pop_front();
				if (m_tdata[15:0] !== want_c.r0)
					report_mismatch("ant0_real", m_tdata[15:0], want_c.r0);
				if (m_tdata[31:16] !== want_c.i0)
					report_mismatch("ant0_imag", m_tdata[31:16], want_c.i0);
				if (m_tdata[47:32] !== want_c.r1)
					report_mismatch("ant1_real", m_tdata[47:32], want_c.r1);
				if (m_tdata[63:48] !== want_c.i1)
					report_mismatch("ant1_imag", m_tdata[63:48], want_c.i1);
				if (m_tuser[0] !== want_c.w0)
					report_mismatch("ant0_write", 16'(m_tuser[0]), 16'(want_c.w0));
				if (m_tuser[1] !== want_c.w1)
					report_mismatch("ant1_write", 16'(m_tuser[1]), 16'(want_c.w1));
				if (m_tuser[2] !== want_c.step)
					report_mismatch("carrier_step", 16'(m_tuser[2]), 16'(want_c.step));
				if (m_tlast !== want_c.last)
					report_mismatch("last", 16'(m_tlast), 16'(want_c.last));
				results_checked++;
			end
		end
	end

	// Entered and left on a falling edge; valid stays high when the next item follows.
	task automatic push_item(logic [11:0] bits, logic odd, logic typed, res_t want);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata <= {4'b0, bits};
		s_tuser <= odd;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		if (typed)
			pending_carriers.push_back(want);
		else
			map_item(bits, odd);
		items_sent++;
		@(negedge clk);
	endtask

	// An ignored item leaves nothing pending, so the extra cycles cover the pipeline.
	task automatic drain();
		int n;
		s_tvalid <= 1'b0;
		for (n = 0; n < 20000 && pending_carriers.size() != 0; n++)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (pending_carriers.size() != 0) begin
			report_mismatch("results never arrived", 16'(pending_carriers.size()), 16'h0);
			pending_carriers.delete();
		end
	endtask

	task automatic program_regs();
		drain();
		foreach (reg_plan[k]) begin
			cfg_index <= reg_plan[k].idx;
			cfg_data <= reg_plan[k].val;
			cfg_valid <= 1'b1;
			do
				@(posedge clk);
			while (!cfg_ready);
			case (reg_plan[k].idx)
				REG_MODULATION: mod_r = reg_plan[k].val[1:0];
				REG_ANT_MODE:   ant_r = reg_plan[k].val[1:0];
				REG_AMPLITUDE:  amp_r = reg_plan[k].val;
				REG_Q16_A:      q16a_r = reg_plan[k].val;
				REG_Q16_B:      q16b_r = reg_plan[k].val;
				REG_Q64_A:      q64a_r = reg_plan[k].val;
				REG_Q64_B:      q64b_r = reg_plan[k].val;
				REG_Q64_C:      q64c_r = reg_plan[k].val;
				default: ;
			endcase
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
		reg_plan.delete();
		settings_used++;
	endtask

	initial begin
		#8_000_000;
		$display("FAIL qam_mapper_alamouti_core");
		$finish;
	end

	initial begin
		int ph;
		int s;
		int n;
		int directed_items;
		logic [1:0] mod_pick;
		logic [1:0] ant_pick;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		mod_r = MOD_QPSK;
		ant_r = ANT_SINGLE;
		amp_r = 15'd32767;
		q16a_r = '0;
		q16b_r = '0;
		q64a_r = '0;
		q64b_r = '0;
		q64c_r = '0;
		mismatches = 0;
		items_sent = 0;
		results_checked = 0;
		settings_used = 0;
		send_pct = 15;
		recv_pct = 66;

		// Reset state: QPSK at full amplitude, single antenna.
		plan.push_back(item_row(12'h003, 1'b0, 1'b1,
				mk_res(16'h5A81, 16'h5A81, 16'h0, 16'h0, 1'b1, 1'b0, 1'b0, 1'b1)));
		plan.push_back(item_row(12'h000, 1'b1, 1'b1,
				mk_res(16'hA57F, 16'hA57F, 16'h0, 16'h0, 1'b1, 1'b0, 1'b0, 1'b1)));
		plan.push_back(cfg_row(REG_AMPLITUDE, 15'd0));
		plan.push_back(item_row(12'hFFF, 1'b0, 1'b1,
				mk_res(16'h0, 16'h0, 16'h0, 16'h0, 1'b1, 1'b0, 1'b0, 1'b1)));
		// The unused modulation code writes no antenna.
		plan.push_back(cfg_row(REG_MODULATION, 15'(MOD_UNUSED)));
		plan.push_back(cfg_row(REG_AMPLITUDE, 15'd32767));
		plan.push_back(item_row(12'hFFF, 1'b0, 1'b1,
				mk_res(16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b0, 1'b0, 1'b1)));
		plan.push_back(cfg_row(REG_ANT_MODE, 15'(ANT_CYCLE)));
		plan.push_back(item_row(12'h555, 1'b1, 1'b1,
				mk_res(16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b0, 1'b0, 1'b1)));
		plan.push_back(cfg_row(REG_MODULATION, 15'(MOD_QPSK)));
		plan.push_back(item_row(12'h001, 1'b1, 1'b1,
				mk_res(16'h0, 16'h0, 16'h5A81, 16'hA57F, 1'b0, 1'b1, 1'b0, 1'b1)));
		plan.push_back(item_row(12'h002, 1'b0, 1'b1,
				mk_res(16'hA57F, 16'h5A81, 16'h0, 16'h0, 1'b1, 1'b0, 1'b0, 1'b1)));
		plan.push_back(cfg_row(REG_ANT_MODE, 15'(ANT_ALAMOUTI)));
		plan.push_back(cfg_row(REG_MODULATION, 15'(MOD_UNUSED)));
		plan.push_back(item_row(12'hFFF, 1'b0, 1'b0, '0));
		plan.push_back(cfg_row(REG_MODULATION, 15'(MOD_QPSK)));
		plan.push_back(item_row(12'h000, 1'b0, 1'b0, '0));
		plan.push_back(item_row(12'h00F, 1'b1, 1'b0, '0));
		plan.push_back(item_row(12'h005, 1'b0, 1'b0, '0));
		plan.push_back(cfg_row(REG_MODULATION, 15'(MOD_QAM16)));
		plan.push_back(cfg_row(REG_Q16_A, 15'd32767));
		plan.push_back(cfg_row(REG_Q16_B, 15'd32767));
		plan.push_back(item_row(12'h0FF, 1'b0, 1'b0, '0));
		plan.push_back(item_row(12'h000, 1'b1, 1'b0, '0));
		plan.push_back(item_row(12'hF5A, 1'b0, 1'b0, '0));
		// Every axis lands on -32768, so the negations wrap onto themselves.
		plan.push_back(cfg_row(REG_Q16_B, 15'd2));
		plan.push_back(item_row(12'h0AA, 1'b0, 1'b0, '0));
		plan.push_back(cfg_row(REG_MODULATION, 15'(MOD_QAM64)));
		plan.push_back(cfg_row(REG_Q64_A, 15'd32767));
		plan.push_back(cfg_row(REG_Q64_B, 15'd32767));
		plan.push_back(cfg_row(REG_Q64_C, 15'd32767));
		plan.push_back(item_row(12'hFFF, 1'b0, 1'b0, '0));
		plan.push_back(item_row(12'h000, 1'b1, 1'b0, '0));
		plan.push_back(item_row(12'h924, 1'b0, 1'b0, '0));
		plan.push_back(cfg_row(REG_ANT_MODE, 15'(ANT_SINGLE)));
		plan.push_back(cfg_row(REG_Q64_A, 15'd1));
		plan.push_back(cfg_row(REG_Q64_B, 15'd2));
		plan.push_back(cfg_row(REG_Q64_C, 15'd4));
		plan.push_back(item_row(12'h3F6, 1'b1, 1'b0, '0));
		// The unused antenna mode drops the item.
		plan.push_back(cfg_row(REG_ANT_MODE, 15'(ANT_UNUSED)));
		plan.push_back(item_row(12'hABC, 1'b1, 1'b0, '0));
		plan.push_back(cfg_row(REG_ANT_MODE, 15'(ANT_CYCLE)));
		plan.push_back(cfg_row(REG_Q64_A, 15'd20000));
		plan.push_back(cfg_row(REG_Q64_B, 15'd9000));
		plan.push_back(cfg_row(REG_Q64_C, 15'd3000));
		plan.push_back(item_row(12'hFFF, 1'b1, 1'b0, '0));
		plan.push_back(item_row(12'h000, 1'b0, 1'b0, '0));
		plan.push_back(item_row(12'h6D9, 1'b1, 1'b0, '0));

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[k]) begin
			if (plan[k].is_cfg) begin
				reg_plan.push_back('{idx: plan[k].idx, val: plan[k].val});
				if (k == plan.size() - 1 || !plan[k + 1].is_cfg)
					program_regs();
			end else begin
				push_item(plan[k].bits, plan[k].odd, plan[k].typed, plan[k].want);
			end
		end
		directed_items = items_sent;

		for (ph = 0; ph < 3; ph++) begin
			drain();
			case (ph)
				0: begin
					send_pct = 15;
					recv_pct = 66;
				end
				1: begin
					send_pct = 66;
					recv_pct = 15;
				end
				default: begin
					send_pct = 0;
					recv_pct = 0;
				end
			endcase
			for (s = 0; s < SETTINGS_PER_PHASE; s++) begin
				mod_pick = ($urandom_range(15) == 0) ? MOD_UNUSED : 2'($urandom_range(2));
				ant_pick = ($urandom_range(11) == 0) ? ANT_UNUSED : 2'($urandom_range(2));
				reg_plan.push_back('{idx: REG_MODULATION, val: 15'(mod_pick)});
				reg_plan.push_back('{idx: REG_ANT_MODE, val: 15'(ant_pick)});
				reg_plan.push_back('{idx: REG_AMPLITUDE, val: pick_level()});
				reg_plan.push_back('{idx: REG_Q16_A, val: pick_level()});
				reg_plan.push_back('{idx: REG_Q16_B, val: pick_level()});
				reg_plan.push_back('{idx: REG_Q64_A, val: pick_level()});
				reg_plan.push_back('{idx: REG_Q64_B, val: pick_level()});
				reg_plan.push_back('{idx: REG_Q64_C, val: pick_level()});
				program_regs();
				n = (ant_pick == ANT_UNUSED) ? 8 : ITEMS_PER_SETTING;
				repeat (n)
					push_item(12'($urandom_range(4095)), 1'($urandom_range(1)), 1'b0, '0);
			end
		end
		drain();

		$display("Mapped %0d input transfers (%0d directed) across %0d register settings;",
				items_sent, directed_items, settings_used);
		$display("%0d result transfers checked, %0d mismatches.", results_checked, mismatches);
		if (mismatches == 0) begin
			$display("PASS qam_mapper_alamouti_core");
		end else begin
			$display("FAIL qam_mapper_alamouti_core");
		end
		$finish;
	end

endmodule
